@@ hw/rtl/svuv_pkg.sv @@
// types, constants and arithmetic steps of the uv-sphere vertex generator
package svuv_pkg;

  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned ISQ_STEPS    = 32;

  localparam logic [11:0] RING_LIMIT    = 12'd255;
  localparam logic [11:0] SEGMENT_LIMIT = 12'd255;

  localparam logic [14:0] RADIUS_RST = 15'd768;
  localparam logic [14:0] STEP_RST   = 15'd1092;

  localparam logic [15:0] PHI_BASE = 16'hC000;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0] HALF_TURN   = 36'sd2147483648;

  typedef enum logic [1:0] {
    REG_RADIUS    = 2'd0,
    REG_SEG_STEP  = 2'd1,
    REG_RING_STEP = 2'd2,
    REG_SPARE     = 2'd3
  } cfg_reg_e;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  // rotation state: x, y in q30, z in 1/2^32 turn
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               flip;
  } rot_t;

  // vectoring state
  typedef struct packed {
    logic signed [35:0] re;
    logic signed [35:0] im;
    logic signed [35:0] z;
    logic               zero;
  } vec_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } isq_t;

  typedef struct packed {
    logic        upper;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
  } vtx_t;

  function automatic rot_t rot_init(logic [15:0] ang);
    rot_t             r;
    logic signed [15:0] a;
    a      = $signed(ang);
    r.flip = 1'b0;
    if (a > 16'sd16384) begin
      a      = a - 16'sh8000;
      r.flip = 1'b1;
    end else if (a < -16'sd16384) begin
      a      = a + 16'sh8000;
      r.flip = 1'b1;
    end
    r.x = CORDIC_GAIN;
    r.y = '0;
    r.z = {a[15], a, 16'h0000};
    return r;
  endfunction

  function automatic rot_t rot_step(rot_t a, int unsigned i);
    rot_t             r;
    logic signed [32:0] at;
    at     = $signed({1'b0, ATAN_TURN[i]});
    r.flip = a.flip;
    if (!a.z[32]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - at;
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + at;
    end
    return r;
  endfunction

  function automatic vec_t vec_init(logic signed [35:0] im, logic signed [35:0] re);
    vec_t r;
    r.zero = (im == '0) && (re == '0);
    r.re   = re;
    r.im   = im;
    r.z    = '0;
    if (re[35]) begin
      r.z  = im[35] ? -HALF_TURN : HALF_TURN;
      r.re = -re;
      r.im = -im;
    end
    return r;
  endfunction

  function automatic vec_t vec_step(vec_t a, int unsigned i);
    vec_t             r;
    logic signed [35:0] at;
    at     = $signed({4'h0, ATAN_TURN[i]});
    r.zero = a.zero;
    if (!a.im[35] && (a.im != '0)) begin
      r.re = a.re + (a.im >>> i);
      r.im = a.im - (a.re >>> i);
      r.z  = a.z + at;
    end else begin
      r.re = a.re - (a.im >>> i);
      r.im = a.im + (a.re >>> i);
      r.z  = a.z - at;
    end
    return r;
  endfunction

  function automatic isq_t isq_step(isq_t a, int unsigned k);
    isq_t        r;
    logic [63:0] b;
    b = 64'd1 << (62 - 2 * k);
    if (a.n >= a.res + b) begin
      r.n   = a.n - (a.res + b);
      r.res = (a.res >> 1) + b;
    end else begin
      r.n   = a.n;
      r.res = a.res >> 1;
    end
    return r;
  endfunction

  function automatic logic [15:0] pos_q8(logic [14:0] r, logic signed [31:0] d);
    logic signed [47:0] p;
    logic signed [47:0] s;
    p = $signed({1'b0, r}) * d;
    s = (p + 48'sd536870912) >>> 30;
    if (s > 48'sd32767) begin
      return 16'h7FFF;
    end else if (s < -48'sd32768) begin
      return 16'h8000;
    end
    return s[15:0];
  endfunction

  function automatic logic [16:0] tex_clamp(logic signed [39:0] t);
    logic signed [39:0] s;
    s = t >>> 16;
    if (s[39]) begin
      return '0;
    end else if (s > 40'sd65536) begin
      return 17'h10000;
    end
    return s[16:0];
  endfunction

  function automatic logic [16:0] tex_u_of(vec_t a);
    logic signed [39:0] z;
    z = a.zero ? 40'sd0 : 40'(a.z);
    return tex_clamp(z + 40'sd2147483648 + 40'sd32768);
  endfunction

  function automatic logic [16:0] tex_v_of(vec_t a);
    logic signed [39:0] z;
    z = a.zero ? 40'sd0 : 40'(a.z);
    return tex_clamp(40'sd2147483648 - (z <<< 1) + 40'sd32768);
  endfunction

endpackage

@@ hw/rtl/sphere_vertex_uv_generator.sv @@
// uv-sphere vertex generator: grid point in, lower and upper vertex out
//
// Input channel (in_valid_i / in_ready_o) takes one grid point: ring and
// segment index. Output channel (out_valid_o / out_ready_i) gives two items
// per grid point, the lower vertex first, then the upper one with
// upper_last_o set. Each item carries position (q8.8) and texture (q1.16).
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) set radius and the two
// angle steps; index 3 is ignored. Write them only while the block is empty.
// Both vertices of a grid point pass through the same registered pipe, the
// upper vertex directly behind the lower one. The output channel moves one
// vertex per cycle while out_ready_i is high; the 95-stage datapath (sin/cos
// cordic, products, integer square root and two vectoring cordics, one step
// per stage) takes one vertex per cycle when it is not stalled.
// A new grid point is taken while the previous one's upper vertex enters
// the pipe. Reset empties the pipe and loads the default radius and steps.
// When the receiver stalls, the whole pipe holds; nothing is lost or repeated.
module sphere_vertex_uv_generator #(
  parameter logic [11:0] RING_LIMIT    = svuv_pkg::RING_LIMIT,
  parameter logic [11:0] SEGMENT_LIMIT = svuv_pkg::SEGMENT_LIMIT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ring_index_i,
  input  logic [7:0]  segment_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [15:0] pos_z_o,
  output logic [16:0] tex_u_o,
  output logic [16:0] tex_v_o,
  output logic        upper_last_o
);

  localparam int unsigned NCS = svuv_pkg::CORDIC_STEPS;
  localparam int unsigned NIS = svuv_pkg::ISQ_STEPS;
  localparam int unsigned NST = 2 + NCS + 3 + NIS + 1 + NCS + 1;

  logic [14:0] radius_q, seg_step_q, ring_step_q;
  logic        hv_q, ph_q;
  logic [7:0]  ring_q, seg_q;
  logic [7:0]  ring_c, seg_c;
  logic        adv;
  logic [NST-1:0] vld_q;

  logic [15:0] theta_q, phi_q;
  logic        up0_q;
  logic [8:0]  ring_sel;
  logic [23:0] phi_prod, theta_prod;

  svuv_pkg::rot_t rt_q [NCS+1];
  svuv_pkg::rot_t rp_q [NCS+1];
  logic           ru_q [NCS+1];

  logic signed [31:0] ct, st, cp, sp;
  logic signed [63:0] pm_a, pm_b, rm_a, rm_b;
  logic signed [31:0] m_dx_q, m_dy_q, m_dz_q;
  logic               m_up_q;

  logic signed [63:0] sq_x, sq_z;
  svuv_pkg::vtx_t     q_vtx_q;
  logic signed [31:0] q_dy_q;
  logic [63:0]        q_sxx_q, q_szz_q;
  svuv_pkg::vec_t     q_va_q;

  svuv_pkg::isq_t     md_i_q [NIS+1];
  svuv_pkg::vec_t     md_a_q [NIS+1];
  svuv_pkg::vtx_t     md_s_q [NIS+1];
  logic signed [31:0] md_dy_q [NIS+1];

  svuv_pkg::vec_t b_a_q [NCS+1];
  svuv_pkg::vtx_t b_s_q [NCS+1];
  logic [16:0]    b_u_q [NCS+1];

  svuv_pkg::vtx_t o_vtx_q;
  logic [16:0]    o_u_q, o_v_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= svuv_pkg::RADIUS_RST;
      seg_step_q  <= svuv_pkg::STEP_RST;
      ring_step_q <= svuv_pkg::STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svuv_pkg::REG_RADIUS:    radius_q    <= cfg_data_i;
        svuv_pkg::REG_SEG_STEP:  seg_step_q  <= cfg_data_i;
        svuv_pkg::REG_RING_STEP: ring_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o = !hv_q || (ph_q && adv);

  assign ring_c = ({4'h0, ring_index_i} > RING_LIMIT) ? RING_LIMIT[7:0] : ring_index_i;
  assign seg_c  = ({4'h0, segment_index_i} > SEGMENT_LIMIT) ?
                  SEGMENT_LIMIT[7:0] : segment_index_i;

  // item holding register, issues lower then upper vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
      ph_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      hv_q <= 1'b1;
      ph_q <= 1'b0;
    end else if (adv && hv_q) begin
      if (ph_q) begin
        hv_q <= 1'b0;
      end else begin
        ph_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ring_q <= ring_c;
      seg_q  <= seg_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], hv_q};
    end
  end

  // angles
  assign ring_sel   = {1'b0, ring_q} + {8'h00, ph_q};
  assign phi_prod   = ring_sel * ring_step_q;
  assign theta_prod = seg_q * seg_step_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      theta_q <= theta_prod[15:0];
      phi_q   <= phi_prod[15:0] + svuv_pkg::PHI_BASE;
      up0_q   <= ph_q;
      rt_q[0] <= svuv_pkg::rot_init(theta_q);
      rp_q[0] <= svuv_pkg::rot_init(phi_q);
      ru_q[0] <= up0_q;
    end
  end

  for (genvar i = 0; i < NCS; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_q[i+1] <= svuv_pkg::rot_step(rt_q[i], i);
        rp_q[i+1] <= svuv_pkg::rot_step(rp_q[i], i);
        ru_q[i+1] <= ru_q[i];
      end
    end
  end

  // direction
  assign ct   = rt_q[NCS].flip ? -rt_q[NCS].x[31:0] : rt_q[NCS].x[31:0];
  assign st   = rt_q[NCS].flip ? -rt_q[NCS].y[31:0] : rt_q[NCS].y[31:0];
  assign cp   = rp_q[NCS].flip ? -rp_q[NCS].x[31:0] : rp_q[NCS].x[31:0];
  assign sp   = rp_q[NCS].flip ? -rp_q[NCS].y[31:0] : rp_q[NCS].y[31:0];
  assign pm_a = st * cp;
  assign pm_b = ct * cp;
  assign rm_a = pm_a + 64'sd536870912;
  assign rm_b = pm_b + 64'sd536870912;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_dx_q <= rm_a[61:30];
      m_dy_q <= rm_b[61:30];
      m_dz_q <= sp;
      m_up_q <= ru_q[NCS];
    end
  end

  // positions, squares, first vectoring set-up
  assign sq_x = m_dx_q * m_dx_q;
  assign sq_z = m_dz_q * m_dz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_vtx_q.upper <= m_up_q;
      q_vtx_q.px    <= svuv_pkg::pos_q8(radius_q, m_dx_q);
      q_vtx_q.py    <= svuv_pkg::pos_q8(radius_q, m_dy_q);
      q_vtx_q.pz    <= svuv_pkg::pos_q8(radius_q, m_dz_q);
      q_dy_q        <= m_dy_q;
      q_sxx_q       <= sq_x;
      q_szz_q       <= sq_z;
      q_va_q        <= svuv_pkg::vec_init(36'(m_dx_q), 36'(m_dz_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      md_i_q[0].n   <= q_sxx_q + q_szz_q;
      md_i_q[0].res <= '0;
      md_a_q[0]     <= q_va_q;
      md_s_q[0]     <= q_vtx_q;
      md_dy_q[0]    <= q_dy_q;
    end
  end

  // square root alongside the u angle
  for (genvar k = 0; k < NIS; k++) begin : g_isq
    always_ff @(posedge clk_i) begin
      if (adv) begin
        md_i_q[k+1]  <= svuv_pkg::isq_step(md_i_q[k], k);
        md_s_q[k+1]  <= md_s_q[k];
        md_dy_q[k+1] <= md_dy_q[k];
      end
    end
    if (k < NCS) begin : g_va
      always_ff @(posedge clk_i) begin
        if (adv) begin
          md_a_q[k+1] <= svuv_pkg::vec_step(md_a_q[k], k);
        end
      end
    end else begin : g_vh
      always_ff @(posedge clk_i) begin
        if (adv) begin
          md_a_q[k+1] <= md_a_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_a_q[0] <= svuv_pkg::vec_init(36'(md_dy_q[NIS]),
                                     $signed({4'h0, md_i_q[NIS].res[31:0]}));
      b_s_q[0] <= md_s_q[NIS];
      b_u_q[0] <= svuv_pkg::tex_u_of(md_a_q[NIS]);
    end
  end

  // v angle
  for (genvar j = 0; j < NCS; j++) begin : g_vb
    always_ff @(posedge clk_i) begin
      if (adv) begin
        b_a_q[j+1] <= svuv_pkg::vec_step(b_a_q[j], j);
        b_s_q[j+1] <= b_s_q[j];
        b_u_q[j+1] <= b_u_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_vtx_q <= b_s_q[NCS];
      o_u_q   <= b_u_q[NCS];
      o_v_q   <= svuv_pkg::tex_v_of(b_a_q[NCS]);
    end
  end

  assign out_valid_o  = vld_q[NST-1];
  assign pos_x_o      = o_vtx_q.px;
  assign pos_y_o      = o_vtx_q.py;
  assign pos_z_o      = o_vtx_q.pz;
  assign tex_u_o      = o_u_q;
  assign tex_v_o      = o_v_q;
  assign upper_last_o = o_vtx_q.upper;

endmodule

@@ hw/rtl/svuv_checker.sv @@
// port checks for the uv-sphere vertex generator, bound to the top level
module svuv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] pos_x_o,
  input logic [15:0] pos_y_o,
  input logic [15:0] pos_z_o,
  input logic [16:0] tex_u_o,
  input logic [16:0] tex_v_o,
  input logic        upper_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o)
      && $stable(pos_z_o) && $stable(tex_u_o) && $stable(tex_v_o) && $stable(upper_last_o))
    else $error("stalled output item changed");

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !upper_last_o |=> out_valid_o && upper_last_o)
    else $error("lower vertex not followed by upper vertex");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= 17'h10000) && (tex_v_o <= 17'h10000))
    else $error("texture coordinate above one");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight after reset");

endmodule

bind sphere_vertex_uv_generator svuv_checker u_svuv_checker (.*);
